FILE: rtl/dq_pkg.sv
// Shared codes and control types for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int WordW = 32;
  localparam int OccW  = 8;

  // Operation codes carried on kind_i.
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // update pointers, write or read the store
  } dq_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dq_ctrl.sv
// Controller state machine for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  output dq_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q == ST_EXEC);
  assign done_o = (state_q == ST_RESP);
  assign accept = start && !busy;

  assign cmd_o.capture = accept;
  assign cmd_o.execute = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = accept ? ST_EXEC : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dq_datapath.sv
// Datapath of the double-ended queue: ring store, head pointer and count.
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dq_cmd_t                 cmd_i,
  input  logic [1:0]              kind_i,
  input  logic signed [WordW-1:0] value_i,
  output logic signed [WordW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic [OccW-1:0]         occupancy_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [1:0]       kind_q;
  logic [WordW-1:0] value_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [1:0]       status_q, status_d;
  logic             pop_ok_q, pop_ok_d;
  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rd_q;

  logic             full, empty;
  logic [AW-1:0]    head_dec, head_inc, back_idx, last_idx;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = ring_add(head_q, CW'(1));
  assign back_idx = ring_add(head_q, count_q);
  assign last_idx = ring_add(head_q, count_q - CW'(1));

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = back_idx;
    rd_addr  = head_q;
    if (cmd_i.execute) begin
      status_d = STATUS_OK;
      pop_ok_d = 1'b0;
      unique case (kind_q)
        KIND_PUSH_FRONT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
            head_d  = head_dec;
            count_d = count_q + CW'(1);
          end
        end
        KIND_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            rd_en    = 1'b1;
            pop_ok_d = 1'b1;
            head_d   = head_inc;
            count_d  = count_q - CW'(1);
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            rd_en    = 1'b1;
            pop_ok_d = 1'b1;
            rd_addr  = last_idx;
            count_d  = count_q - CW'(1);
          end
        end
        default: status_d = STATUS_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= STATUS_OK;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
  end

  // Single-port ring store with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= value_q;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  assign popped_value_o = pop_ok_q ? rd_q : '0;
  assign status_o       = status_q;
  assign occupancy_o    = OccW'(count_q);

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue. Pulse start with kind_i and value_i while busy
// is low to issue a request: push front, push back, pop front or pop back.
// Each request gives exactly one result, shown for a single cycle with
// done_o high; the receiver cannot stall, so capture it in that cycle.
// popped_value_o holds the removed word for a successful pop and zero
// otherwise, status_o reports ok, empty (pop refused) or full (push refused),
// and occupancy_o gives the low 8 bits of the word count after the request.
// A refused request leaves the queue unchanged. Each accepted request moves
// from the execute state to the respond state, in which done_o is high and
// the result is shown. busy is high only in the execute cycle, so a new
// request is taken in the same cycle that the previous result is shown. The
// store needs no clearing after reset: a pop only ever reads a word written
// by an earlier push.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind_i,
  input  logic signed [WordW-1:0] value_i,
  output logic                    done_o,
  output logic signed [WordW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic [OccW-1:0]         occupancy_o
);

  dq_cmd_t cmd;

  // Sequence each request: capture, execute, respond.
  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Hold the ring store, head pointer and count; advance them on execute.
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire

FILE: rtl/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dq_checker
  import dq_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic signed [WordW-1:0] popped_value_o,
  input logic [1:0]              status_o,
  input logic [OccW-1:0]         occupancy_o
);

  // An accepted request goes busy next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not go busy");

  // Execute always ends in a result.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("no result after execute");

  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // Refused requests carry no popped word.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |-> (popped_value_o == '0))
    else $error("refused request returned a word");

  // A pop refused as empty leaves an empty queue.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_EMPTY) |-> (occupancy_o == '0))
    else $error("empty status with nonzero occupancy");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .popped_value_o (popped_value_o),
  .status_o       (status_o),
  .occupancy_o    (occupancy_o)
);

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int QDEPTH      = 128;
  localparam int PtrW        = $clog2(QDEPTH);
  localparam int CycleLimit  = 200000;
  localparam int IdlePercent = 28;

  // One expected result, with the request kind kept for the error report.
  typedef struct {
    logic [1:0]       kind;
    logic [WordW-1:0] popped;
    logic [1:0]       status;
    logic [OccW-1:0]  occupancy;
  } deque_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              kind_i;
  logic signed [WordW-1:0] value_i;
  logic                    done_o;
  logic signed [WordW-1:0] popped_value_o;
  logic [1:0]              status_o;
  logic [OccW-1:0]         occupancy_o;

  // Shadow of the queue contents: ring of words, front pointer, word count.
  logic [WordW-1:0] ring_words [QDEPTH];
  logic [PtrW-1:0]  ring_head;
  logic [OccW-1:0]  ring_count;

  deque_result_t pending_results[$];
  int            mismatch_count;
  int            cycle_count;
  bit            steady_send;

  double_ended_queue #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the shadow queue and return the result it should give.
  function automatic deque_result_t apply_deque_op(logic [1:0] op, logic [WordW-1:0] word);
    deque_result_t  res;
    logic [PtrW-1:0] slot;
    res.kind   = op;
    res.popped = '0;
    res.status = STATUS_OK;
    case (op)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (ring_count == OccW'(QDEPTH)) begin
          res.status = STATUS_FULL;
        end else if (op == KIND_PUSH_FRONT) begin
          // Step the head back, wrapping below zero.
          ring_head = ring_head - 1'b1;
          ring_words[ring_head] = word;
          ring_count = ring_count + 1'b1;
        end else begin
          slot = ring_head + ring_count[PtrW-1:0];
          ring_words[slot] = word;
          ring_count = ring_count + 1'b1;
        end
      end
      default: begin
        if (ring_count == '0) begin
          res.status = STATUS_EMPTY;
        end else if (op == KIND_POP_FRONT) begin
          res.popped = ring_words[ring_head];
          ring_head = ring_head + 1'b1;
          ring_count = ring_count - 1'b1;
        end else begin
          slot = ring_head + PtrW'(ring_count - 1'b1);
          res.popped = ring_words[slot];
          ring_count = ring_count - 1'b1;
        end
      end
    endcase
    res.occupancy = ring_count;
    return res;
  endfunction

  // Hold start high until busy is low at a falling edge; the request is then
  // taken at the next rising edge, so predict it here.
  task automatic issue_request(logic [1:0] op, logic [WordW-1:0] word);
    @(negedge clk_i);
    start   <= 1'b1;
    kind_i  <= op;
    value_i <= word;
    while (busy) @(negedge clk_i);
    pending_results.push_back(apply_deque_op(op, word));
    @(posedge clk_i);
  endtask

  // Drop start now and then, unless sending back to back.
  task automatic maybe_idle();
    int gap;
    if (!steady_send && $urandom_range(99) < IdlePercent) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
  endtask

  // Pick a kind: push with the given percentage, front or back at random.
  function automatic logic [1:0] pick_kind(int push_percent);
    bit front;
    front = $urandom_range(1);
    if ($urandom_range(99) < push_percent) begin
      return front ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
    end
    return front ? KIND_POP_FRONT : KIND_POP_BACK;
  endfunction

  task automatic hold_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Empty pops, extreme words, both head wrap directions, pops with junk values.
  task automatic test_directed_edges();
    issue_request(KIND_POP_FRONT, 32'hDEAD_BEEF);
    issue_request(KIND_POP_BACK, 32'hFFFF_FFFF);
    issue_request(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
    issue_request(KIND_PUSH_BACK, 32'h8000_0000);
    issue_request(KIND_PUSH_FRONT, 32'h0000_0000);
    issue_request(KIND_PUSH_BACK, 32'hFFFF_FFFF);
    issue_request(KIND_PUSH_FRONT, 32'h5555_5555);
    issue_request(KIND_PUSH_BACK, 32'hAAAA_AAAA);
    issue_request(KIND_POP_BACK, 32'h1234_5678);
    issue_request(KIND_POP_FRONT, 32'h0000_0000);
    issue_request(KIND_POP_BACK, 32'h8000_0000);
    issue_request(KIND_POP_FRONT, 32'h7FFF_FFFF);
    issue_request(KIND_POP_FRONT, 32'hFFFF_FFFF);
    issue_request(KIND_POP_BACK, 32'h0000_0001);
    issue_request(KIND_POP_BACK, 32'h0000_0000);
    // Walk the head forward across the top of the ring.
    issue_request(KIND_PUSH_FRONT, 32'h0000_0001);
    issue_request(KIND_PUSH_FRONT, 32'hFFFF_FFFE);
    issue_request(KIND_PUSH_FRONT, 32'h0F0F_0F0F);
    issue_request(KIND_POP_FRONT, 32'h0000_0000);
    issue_request(KIND_POP_FRONT, 32'h0000_0000);
    issue_request(KIND_POP_FRONT, 32'h0000_0000);
    issue_request(KIND_POP_FRONT, 32'h0000_0000);
  endtask

  // Push-heavy until full with refused pushes, then pop-heavy until empty.
  task automatic test_fill_then_drain();
    int full_tries;
    int empty_tries;
    full_tries  = 0;
    empty_tries = 0;
    while (full_tries < 6) begin
      if (ring_count == OccW'(QDEPTH)) full_tries++;
      maybe_idle();
      issue_request(pick_kind(85), $urandom());
    end
    while (empty_tries < 4) begin
      if (ring_count == '0) empty_tries++;
      maybe_idle();
      issue_request(pick_kind(15), $urandom());
    end
  endtask

  // Mixed traffic whose push/pop balance drifts every fifty requests.
  task automatic test_random_walk();
    int push_percent;
    push_percent = 50;
    for (int n = 0; n < 150; n++) begin
      if (n % 50 == 0) push_percent = $urandom_range(25, 75);
      steady_send = (n < 75);
      maybe_idle();
      issue_request(pick_kind(push_percent), $urandom());
    end
    steady_send = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_PUSH_FRONT;
    value_i     = '0;
    ring_head   = '0;
    ring_count  = '0;
    steady_send = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    hold_until_drained();
    test_fill_then_drain();
    test_random_walk();
    hold_until_drained();
    test_fill_then_drain();
    hold_until_drained();

    // Let any stray strobe show up before the verdict.
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Compare each strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: popped=%h status=%0d occupancy=%0d",
                   popped_value_o, status_o, occupancy_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (popped_value_o !== want.popped || status_o !== want.status ||
            occupancy_o !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("kind %0d: expected popped=%h status=%0d occupancy=%0d, got %h %0d %0d",
                     want.kind, want.popped, want.status, want.occupancy,
                     popped_value_o, status_o, occupancy_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
